// File: rtl/jsu_pkg.sv
// Shared types, codes and character constants for the JSON string unescaper.
// No dependencies; used by json_string_unescaper.
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Decode modes (anything else behaves as raw)
    localparam logic [1:0] MODE_RAW        = 2'd0;
    localparam logic [1:0] MODE_STRICT     = 2'd1;
    localparam logic [1:0] MODE_PERMISSIVE = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUBSTITUTE  = 1'd1;

    localparam logic [1:0] DECODE_MODE_RESET = MODE_RAW;
    localparam logic [7:0] SUBSTITUTE_RESET  = 8'd63;

    // Result queue depth (two results can be pushed per item)
    localparam int OUT_DEPTH_DEFAULT = 4;

    // Characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_DEL    = 8'd127;

    // \u code magnitude saturates at 256
    localparam int ACC_W = 9;
    localparam logic [ACC_W-1:0] ACC_SAT = 9'd256;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_BODY      = 5'b00010,
        PH_ESC       = 5'b00100,
        PH_NUM_START = 5'b01000,
        PH_NUM_MORE  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       err;
        logic [7:0] ch;
    } t_filt;

    // Mode filter applied to every decoded character
    function automatic t_filt filt_char(logic [7:0] c, logic [1:0] mode,
                                        logic [7:0] sub);
        t_filt r;
        r.err = 1'b0;
        r.ch  = c;
        case (mode)
            MODE_STRICT: begin
                if (c >= CH_DEL) r.err = 1'b1;
            end
            MODE_PERMISSIVE: begin
                if (c < CH_SPACE || c >= CH_DEL) r.ch = sub;
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/json_string_unescaper.sv
// JSON string unescaper top level: input register, decode logic, result queue.
// Depends on jsu_pkg.

// Decodes one JSON string at a time from a byte stream. Each input item is a
// byte (or an end-of-input mark); each result item is a decoded character, a
// string-complete mark or a parse error, with is_last set on the final result
// that an input item causes. An item is registered on entry, decoded from the
// input register by single-level logic, and its zero, one or two results are
// pushed into a small result queue, from which the output is presented. The
// block takes one item per cycle as long as the result queue has room for two
// results; the output port drains one result per cycle while i_out_ready is
// high, so the byte that ends a \u number (which can give two results) can
// hold up the input. Configuration writes are always accepted and take effect
// on the next cycle.
module json_string_unescaper #(
    parameter int OUT_DEPTH = jsu_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_byte_value,
    input  logic                             i_end_of_input,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_char_value,
    output logic [1:0]                       o_result_kind,
    output logic                             o_is_last,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [jsu_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);

    localparam int PW = (OUT_DEPTH > 2) ? $clog2(OUT_DEPTH) : 1;
    localparam int CW = $clog2(OUT_DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic [1:0] r_mode;
    logic [7:0] r_sub;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::DECODE_MODE_RESET;
            r_sub  <= jsu_pkg::SUBSTITUTE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jsu_pkg::REG_DECODE_MODE: r_mode <= i_cfg_data[1:0];
                jsu_pkg::REG_SUBSTITUTE:  r_sub  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic [CW-1:0] r_count;
    logic       room;
    logic       proc;

    assign room       = (r_count <= CW'(OUT_DEPTH - 2));
    assign proc       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_value;
            r_in_eoi  <= i_end_of_input;
        end
    end

    // decode state
    jsu_pkg::t_phase         r_phase, n_phase;
    logic [jsu_pkg::ACC_W-1:0] r_acc, n_acc;
    logic                    r_neg, n_neg;
    logic                    r_seen, n_seen;

    jsu_pkg::t_result res0, res1, err_res;
    logic [1:0]       nr;

    // body byte path, shared by the body phase and the end of a number
    jsu_pkg::t_filt   fb, fc;
    jsu_pkg::t_result bb_res;
    logic             bb_emit;
    jsu_pkg::t_phase  bb_phase;

    // escape path
    logic             esc_known;
    logic [7:0]       esc_ch;
    jsu_pkg::t_filt   fe;

    logic             is_digit;
    logic [11:0]      acc_next;
    logic             num_bad;

    assign err_res = '{ch: 8'h00, kind: jsu_pkg::KIND_ERROR, last: 1'b0};

    always_comb begin
        fb       = jsu_pkg::filt_char(r_in_byte, r_mode, r_sub);
        bb_emit  = 1'b1;
        bb_res   = '{ch: 8'h00, kind: jsu_pkg::KIND_DONE, last: 1'b0};
        bb_phase = jsu_pkg::PH_IDLE;
        if (r_in_byte == jsu_pkg::CH_QUOTE) begin
            bb_phase = jsu_pkg::PH_IDLE;
        end else if (r_in_byte == jsu_pkg::CH_BSLASH) begin
            bb_emit  = 1'b0;
            bb_phase = jsu_pkg::PH_ESC;
        end else if (fb.err) begin
            bb_res   = err_res;
            bb_phase = jsu_pkg::PH_IDLE;
        end else begin
            bb_res   = '{ch: fb.ch, kind: jsu_pkg::KIND_CHAR, last: 1'b0};
            bb_phase = jsu_pkg::PH_BODY;
        end
    end

    always_comb begin
        esc_known = 1'b1;
        esc_ch    = r_in_byte;
        case (r_in_byte)
            jsu_pkg::CH_LOW_T:  esc_ch = jsu_pkg::CH_TAB;
            jsu_pkg::CH_LOW_N:  esc_ch = jsu_pkg::CH_LF;
            jsu_pkg::CH_LOW_R:  esc_ch = jsu_pkg::CH_CR;
            jsu_pkg::CH_LOW_F:  esc_ch = jsu_pkg::CH_FF;
            jsu_pkg::CH_SLASH:  esc_ch = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_BSLASH: esc_ch = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_QUOTE:  esc_ch = jsu_pkg::CH_QUOTE;
            default:            esc_known = 1'b0;
        endcase
        fe = jsu_pkg::filt_char(esc_ch, r_mode, r_sub);
    end

    always_comb begin
        is_digit = (r_in_byte >= jsu_pkg::CH_ZERO) && (r_in_byte <= jsu_pkg::CH_NINE);
        acc_next = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {8'h00, r_in_byte[3:0]};
        num_bad  = !r_seen || (r_neg && r_acc != '0) || r_acc[jsu_pkg::ACC_W-1];
        fc       = jsu_pkg::filt_char(r_acc[7:0], r_mode, r_sub);
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_seen  = r_seen;
        res0    = err_res;
        res1    = err_res;
        nr      = 2'd0;
        if (r_in_eoi) begin
            if (r_phase != jsu_pkg::PH_IDLE) nr = 2'd1;
            n_phase = jsu_pkg::PH_IDLE;
        end else begin
            case (r_phase)
                jsu_pkg::PH_BODY: begin
                    res0    = bb_res;
                    nr      = {1'b0, bb_emit};
                    n_phase = bb_phase;
                end
                jsu_pkg::PH_ESC: begin
                    nr = 2'd1;
                    if (r_in_byte == jsu_pkg::CH_LOW_U) begin
                        nr      = 2'd0;
                        n_phase = jsu_pkg::PH_NUM_START;
                        n_acc   = '0;
                        n_neg   = 1'b0;
                        n_seen  = 1'b0;
                    end else if (!esc_known || fe.err) begin
                        n_phase = jsu_pkg::PH_IDLE;
                    end else begin
                        res0    = '{ch: fe.ch, kind: jsu_pkg::KIND_CHAR, last: 1'b0};
                        n_phase = jsu_pkg::PH_BODY;
                    end
                end
                jsu_pkg::PH_NUM_START, jsu_pkg::PH_NUM_MORE: begin
                    if (is_digit) begin
                        n_acc   = (acc_next > 12'(jsu_pkg::ACC_SAT)) ? jsu_pkg::ACC_SAT
                                                                    : acc_next[8:0];
                        n_seen  = 1'b1;
                        n_phase = jsu_pkg::PH_NUM_MORE;
                    end else if (r_phase == jsu_pkg::PH_NUM_START &&
                                 (r_in_byte == jsu_pkg::CH_MINUS ||
                                  r_in_byte == jsu_pkg::CH_PLUS)) begin
                        n_neg   = (r_in_byte == jsu_pkg::CH_MINUS);
                        n_phase = jsu_pkg::PH_NUM_MORE;
                    end else if (num_bad || fc.err) begin
                        // ending byte is consumed with the error
                        nr      = 2'd1;
                        n_phase = jsu_pkg::PH_IDLE;
                    end else begin
                        // code character, then the ending byte as a body byte
                        res0    = '{ch: fc.ch, kind: jsu_pkg::KIND_CHAR, last: 1'b0};
                        res1    = bb_res;
                        nr      = bb_emit ? 2'd2 : 2'd1;
                        n_phase = bb_phase;
                    end
                end
                default: begin
                    if (r_in_byte == jsu_pkg::CH_QUOTE) begin
                        n_phase = jsu_pkg::PH_BODY;
                    end else if (!(r_in_byte == jsu_pkg::CH_SPACE ||
                                   r_in_byte == jsu_pkg::CH_TAB ||
                                   r_in_byte == jsu_pkg::CH_CR ||
                                   r_in_byte == jsu_pkg::CH_LF)) begin
                        nr      = 2'd1;
                        n_phase = jsu_pkg::PH_IDLE;
                    end
                end
            endcase
        end
        res0.last = (nr == 2'd1);
        res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_IDLE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
        end else if (proc) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
        end
    end

    // result queue
    jsu_pkg::t_result r_fifo [OUT_DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [PW-1:0]    wr_ptr1;
    logic [CW-1:0]    n_count;
    logic [1:0]       push;
    logic             pop;

    assign wr_ptr1 = ptr_inc(r_wr_ptr);
    assign push    = proc ? nr : 2'd0;
    assign pop     = o_out_valid && i_out_ready;
    assign n_count = r_count + CW'(push) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) r_fifo[r_wr_ptr] <= res0;
        if (push == 2'd2) r_fifo[wr_ptr1]  <= res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push == 2'd1) r_wr_ptr <= wr_ptr1;
            else if (push == 2'd2) r_wr_ptr <= ptr_inc(wr_ptr1);
            if (pop) r_rd_ptr <= ptr_inc(r_rd_ptr);
        end
    end

    assign o_out_valid   = (r_count != '0);
    assign o_char_value  = r_fifo[r_rd_ptr].ch;
    assign o_result_kind = r_fifo[r_rd_ptr].kind;
    assign o_is_last     = r_fifo[r_rd_ptr].last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(OUT_DEPTH))
        else $error("result queue overflow");

    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_eoi) |=> (r_phase == jsu_pkg::PH_IDLE))
        else $error("end of input did not return to idle");

    a_error_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push != 2'd0 && (res0.kind == jsu_pkg::KIND_ERROR ||
                          (push == 2'd2 && res1.kind == jsu_pkg::KIND_ERROR)))
        |=> (r_phase == jsu_pkg::PH_IDLE))
        else $error("error result without return to idle");

    a_pair_char_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push == 2'd2) |-> (res0.kind == jsu_pkg::KIND_CHAR && !res0.last))
        else $error("two-result item without leading character");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result_kind != 2'd3))
        else $error("invalid result kind at output");

endmodule
